[sv/te2f_pkg.sv]
// ----------------------------------------------------------------------------
// te2f_pkg
// Shared types and constants of the tensor element to float32 converter.
// ----------------------------------------------------------------------------
package te2f_pkg;

  // Element type codes.
  typedef enum logic [1:0] {
    ET_SINGLE = 2'd0,
    ET_INT8   = 2'd1,
    ET_HALF   = 2'd2,
    ET_BAD    = 2'd3
  } elem_type_t;

  // Register indexes (word address).
  localparam logic [1:0] REG_ELEMENT_TYPE = 2'd0;
  localparam logic [1:0] REG_ZERO_POINT   = 2'd1;
  localparam logic [1:0] REG_SCALE_BITS   = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN        = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

  // Configuration snapshot handed to the datapath.
  typedef struct packed {
    elem_type_t  etype;
    logic [7:0]  zero_point;
    logic [31:0] scale_bits;
  } cfg_t;

endpackage

[sv/te2f_regs.sv]
// ----------------------------------------------------------------------------
// te2f_regs
// APB-style register file holding element type, zero point and scale.
// ----------------------------------------------------------------------------
module te2f_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output te2f_pkg::cfg_t   cfg
);
  import te2f_pkg::*;

  logic [1:0] widx;
  assign widx   = paddr[3:2];
  assign pready = 1'b1;

  // Register writes happen on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.etype      <= ET_SINGLE;
      cfg.zero_point <= 8'd0;
      cfg.scale_bits <= SCALE_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (widx)
        REG_ELEMENT_TYPE: cfg.etype      <= elem_type_t'(pwdata[1:0]);
        REG_ZERO_POINT:   cfg.zero_point <= pwdata[7:0];
        REG_SCALE_BITS:   cfg.scale_bits <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (widx)
      REG_ELEMENT_TYPE: prdata = {30'd0, cfg.etype};
      REG_ZERO_POINT:   prdata = {24'd0, cfg.zero_point};
      REG_SCALE_BITS:   prdata = cfg.scale_bits;
      default:          prdata = 32'd0;
    endcase
  end
endmodule

[sv/te2f_pipe.sv]
// ----------------------------------------------------------------------------
// te2f_pipe
// Four-stage conversion pipeline with a stall-shared enable.
// Stage 1: difference, half decode. Stage 2: multiply, leading-one search.
// Stage 3: normalize and round. Stage 4: pack result.
// ----------------------------------------------------------------------------
module te2f_pipe (
  input  logic           clk,
  input  logic           rst,
  input  te2f_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_raw,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_bits,
  output logic           out_bad,
  output logic           out_last
);
  import te2f_pkg::*;

  logic adv;
  logic v1, v2, v3, v4;
  assign adv      = !v4 || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1 ----------------
  logic        k1;          // 0 direct, 1 int8 math
  logic [31:0] d1_bits;     // direct result
  logic        bad1, last1, sign1;
  logic [7:0]  m1;          // |difference|, up to 255
  logic [23:0] sig1;
  logic [8:0]  e1;

  logic signed [8:0] diff_c;
  logic [7:0]  mag_c;
  logic [31:0] dq_bits_c, half_c;
  logic        dq_direct_c, sgn_c;
  logic [7:0]  sexp;
  logic [22:0] sman;
  logic [15:0] hb;
  logic [4:0]  hex;
  logic [9:0]  hman;
  logic [4:0]  lz;
  logic [9:0]  hnorm;

  always_comb begin
    sexp   = cfg.scale_bits[30:23];
    sman   = cfg.scale_bits[22:0];
    diff_c = $signed({in_raw[7], in_raw[7:0]}) - $signed({cfg.zero_point[7], cfg.zero_point});
    mag_c  = diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
    sgn_c  = diff_c[8] ^ cfg.scale_bits[31];
    dq_direct_c = 1'b1;
    dq_bits_c   = {sgn_c, 31'd0};
    if (sexp == 8'hFF) begin
      if (sman != 23'd0)       dq_bits_c = cfg.scale_bits | 32'h0040_0000;
      else if (mag_c == 8'd0)  dq_bits_c = QNAN;
      else                     dq_bits_c = {sgn_c, 31'd0} | INF_BITS;
    end else if (mag_c == 8'd0 || (sexp == 8'd0 && sman == 23'd0)) begin
      dq_bits_c = {sgn_c, 31'd0};
    end else begin
      dq_direct_c = 1'b0;
    end
    // Half widening; a subnormal is normalized by a leading-one count.
    hb   = in_raw[15:0];
    hex  = hb[14:10];
    hman = hb[9:0];
    lz   = 5'd0;
    for (int i = 0; i < 10; i++) begin
      if (hman[i]) lz = 5'(9 - i);
    end
    hnorm = 10'(hman << (lz + 5'd1));
    if (hex == 5'd0) begin
      if (hman == 10'd0) half_c = {hb[15], 31'd0};
      else half_c = {hb[15], 8'(8'd112 - {3'd0, lz}), hnorm, 13'd0};
    end else if (hex == 5'h1F) begin
      half_c = {hb[15], 8'hFF, hman, 13'd0};
    end else begin
      half_c = {hb[15], 8'({3'd0, hex} + 8'd112), hman, 13'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      last1 <= in_last;
      bad1  <= 1'b0;
      k1    <= 1'b0;
      sign1 <= sgn_c;
      m1    <= mag_c;
      sig1  <= (sexp == 8'd0) ? {1'b0, sman} : {1'b1, sman};
      e1    <= (sexp == 8'd0) ? 9'd1 : {1'b0, sexp};
      unique case (cfg.etype)
        ET_SINGLE: d1_bits <= in_raw;
        ET_INT8: begin
          d1_bits <= dq_bits_c;
          k1      <= !dq_direct_c;
        end
        ET_HALF:   d1_bits <= half_c;
        default: begin
          d1_bits <= 32'd0;
          bad1    <= 1'b1;
        end
      endcase
    end
  end

  // ---------------- stage 2 ----------------
  logic [31:0] p2;
  logic [4:0]  h2;
  logic [31:0] d2_bits;
  logic        k2, bad2, last2, sign2;
  logic [8:0]  e2;
  logic [31:0] p_c;
  logic [4:0]  h_c;

  // The product is at most 32 bits; find its leading one.
  always_comb begin
    p_c = {8'd0, sig1} * {24'd0, m1};
    h_c = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (p_c[i]) h_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p2 <= p_c; h2 <= h_c; d2_bits <= d1_bits; k2 <= k1;
      bad2 <= bad1; last2 <= last1; sign2 <= sign1; e2 <= e1;
    end
  end

  // ---------------- stage 3 ----------------
  logic [24:0] q3;
  logic signed [10:0] big3;
  logic [31:0] d3_bits;
  logic        k3, bad3, last3, sign3, norm3;
  logic [22:0] sub3;
  logic signed [10:0] big_c;
  logic [4:0]  sh_c;
  logic [31:0] rem_c, halfw_c, mask_c;
  logic [24:0] q_c;

  always_comb begin
    big_c   = $signed({6'd0, h2}) + $signed({2'd0, e2}) - 11'sd23;
    sh_c    = (h2 > 5'd23) ? 5'(h2 - 5'd23) : 5'd0;
    mask_c  = (32'd1 << sh_c) - 32'd1;
    rem_c   = p2 & mask_c;
    halfw_c = (sh_c == 5'd0) ? 32'd0 : (32'd1 << (sh_c - 5'd1));
    if (h2 > 5'd23) begin
      q_c = 25'(p2 >> sh_c);
      if (rem_c > halfw_c || (rem_c == halfw_c && q_c[0])) q_c = q_c + 25'd1;
    end else begin
      q_c = 25'(p2 << (5'd23 - h2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      q3 <= q_c; big3 <= big_c; norm3 <= (big_c >= 11'sd1);
      // Subnormal: p << (e-1), with e = 1 here for a subnormal scale.
      sub3 <= 23'(p2 << (e2[4:0] - 5'd1));
      d3_bits <= d2_bits; k3 <= k2; bad3 <= bad2; last3 <= last2; sign3 <= sign2;
    end
  end

  // ---------------- stage 4 ----------------
  logic [31:0] res_c;
  logic signed [10:0] bb;
  logic [23:0] qq;
  always_comb begin
    bb = big3;
    qq = q3[23:0];
    if (q3[24]) begin
      qq = q3[24:1];
      bb = big3 + 11'sd1;
    end
    if (!k3) res_c = d3_bits;
    else if (!norm3) res_c = {sign3, 8'd0, sub3};
    else if (bb >= 11'sd255) res_c = {sign3, 31'd0} | INF_BITS;
    else res_c = {sign3, bb[7:0], qq[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_bits <= res_c; out_bad <= bad3; out_last <= last3;
    end
  end
  assign out_valid = v4;
endmodule

[sv/tensor_element_to_float32.sv]
// ----------------------------------------------------------------------------
// tensor_element_to_float32
// Converts tensor elements (float32, int8 quantized, float16) to float32.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis (tdata = raw element, tlast = last marker).
//   Result beats leave on m_axis: tdata = float bits, tuser = unsupported flag,
//   tlast = copy of the input marker.
//   The APB port sets element type (0x0), zero point (0x4) and scale (0x8);
//   write only while the pipeline is empty.
//   A beat accepted at one edge loads the first of the four register stages
//   (decode, multiply, round, pack) at that edge and leaves from the last.
//   Throughput is one beat per cycle while the receiver does not stall;
//   each stage takes one beat per cycle.
//   Reset empties the pipeline and loads type float32, zero point 0, scale 1.0.
//   When the receiver stalls a waiting result, every stage holds and s_axis_tready drops;
//   no beat is lost or repeated.
// ----------------------------------------------------------------------------
module tensor_element_to_float32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] raw_element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] float_bits
  output logic        m_axis_tuser,   // [0] unsupported
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import te2f_pkg::*;

  cfg_t cfg;

  // Configuration registers.
  te2f_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Conversion pipeline.
  te2f_pipe u_pipe (
    .clk, .rst, .cfg,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .in_raw   (s_axis_tdata),  .in_last  (s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_bits (m_axis_tdata),  .out_bad  (m_axis_tuser),
    .out_last (m_axis_tlast)
  );
endmodule
